// File: rtl/core/wfa_pkg.sv
`default_nettype none

package wfa_pkg;

    // widths fixed by the transaction fields
    localparam int unsigned INDEX_W = 5;
    localparam int unsigned SIZE_W  = 16;
    localparam int unsigned COUNT_W = 6;

    typedef logic [0:0]         t_op;
    typedef logic [INDEX_W-1:0] t_index;
    typedef logic [SIZE_W-1:0]  t_size;
    typedef logic [COUNT_W-1:0] t_count;

    localparam t_op OP_LOAD  = 1'b0;
    localparam t_op OP_ALLOC = 1'b1;

endpackage

`default_nettype wire

// File: rtl/core/wfa_req_if.sv
`default_nettype none

interface wfa_req_if;
    import wfa_pkg::*;

    logic   valid;
    logic   ready;
    t_op    operation;
    t_index block_index;
    t_size  size;

    modport source (output valid, output operation, output block_index, output size,
                    input ready);
    modport sink   (input valid, input operation, input block_index, input size,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/wfa_rsp_if.sv
`default_nettype none

interface wfa_rsp_if;
    import wfa_pkg::*;

    logic   valid;
    logic   ready;
    logic   found;
    t_index granted_index;
    t_size  fragment;

    modport source (output valid, output found, output granted_index, output fragment,
                    input ready);
    modport sink   (input valid, input found, input granted_index, input fragment,
                    output ready);
endinterface

`default_nettype wire

// File: rtl/core/worst_fit_block_allocator.sv
`default_nettype none

// worst-fit block allocator: keeps a table of block sizes, each with an allocated mark.
// a load transaction (operation 0) writes one entry's size, marks it free and returns
// nothing; a load to an index at or beyond the table is dropped.
// an allocate transaction (operation 1) scans the free entries below block_count
// (saturated to the table depth) and grants the largest one that is at least the
// request, lowest index on a tie, returning found, granted_index and the leftover
// fragment; when nothing fits it returns all zeros and changes no mark.
// with L the scan length (block_count saturated to the table depth), an allocate keeps
// i_req.ready low until its grant is made: the size table sits in a single-port-read
// ram and one comparator walks it one entry per cycle over the L entries, then the last
// entry read is compared, the sequencer hands over to the grant state and the grant
// follows; with L zero nothing is read.
// the result sits in an output register, so a new transaction can be taken while it
// waits; a grant stalls only if an earlier result has not yet been taken, and the
// block stays busy for as long as that stall lasts.
// entry sizes are undefined after reset and must be loaded before they are scanned;
// the allocated marks clear on reset. block_count is written via i_cfg_we/i_cfg_wdata
// by the user, only while the block is idle; the block itself does not enforce this.

module worst_fit_block_allocator #(
    parameter int unsigned NUM_BLOCKS = 32
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cfg_we,
    input  wire wfa_pkg::t_count i_cfg_wdata,
    wfa_req_if.sink              i_req,
    wfa_rsp_if.source            o_rsp
);
    import wfa_pkg::*;

    // a load can reach index 31 and a scan index 62 at most, so deeper entries are idle
    localparam int unsigned DEPTH = (NUM_BLOCKS < 64) ? NUM_BLOCKS : 64;
    localparam int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW    = $clog2(DEPTH + 1);

    // sequencer codes
    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_FINISH = 2'd2;

    // control
    logic [1:0]       r_state, n_state;
    t_count           r_block_count;
    logic [DEPTH-1:0] r_marks;
    logic [CW-1:0]    r_addr;       // next entry to read
    logic [CW-1:0]    r_limit;      // scan length
    logic             r_rd_pend;    // ram data for r_rd_idx arrives this cycle
    logic             r_have;       // a candidate has been found
    logic             r_out_valid;

    // payload
    t_size            r_req;
    logic [AW-1:0]    r_rd_idx;
    logic             r_rd_mark;
    logic [AW-1:0]    r_best;
    t_size            r_best_size;
    logic             r_found;
    t_index           r_gidx;
    t_size            r_frag;

    // ram hookup
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    t_size            ram_rdata;

    logic             req_xact;
    logic             rsp_xact;
    logic             load_hit;
    logic             issue;
    logic             fits;
    logic             better;
    logic             out_free;
    logic [CW-1:0]    limit_sat;

    assign req_xact = i_req.valid && i_req.ready;
    assign rsp_xact = r_out_valid && o_rsp.ready;
    assign out_free = !r_out_valid || o_rsp.ready;

    // load writes go straight into the table in the accept cycle
    assign load_hit  = (32'(i_req.block_index) < DEPTH);
    assign ram_we    = req_xact && (i_req.operation == OP_LOAD) && load_hit;
    assign ram_waddr = AW'(i_req.block_index);

    // saturate the scan length to the table depth
    assign limit_sat = (32'(r_block_count) > DEPTH) ? CW'(DEPTH) : CW'(r_block_count);

    // the one comparator pair: fits the request, beats the current best
    assign issue  = (r_state == S_SCAN) && (r_addr < r_limit);
    assign fits   = !r_rd_mark && (ram_rdata >= r_req);
    assign better = !r_have || (ram_rdata > r_best_size);

    wfa_ram #(
        .WIDTH (SIZE_W),
        .DEPTH (DEPTH)
    ) u_sizes (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_req.size),
        .i_raddr (r_addr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign i_req.ready = (r_state == S_IDLE);

    assign o_rsp.valid         = r_out_valid;
    assign o_rsp.found         = r_found;
    assign o_rsp.granted_index = r_gidx;
    assign o_rsp.fragment      = r_frag;

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (req_xact && (i_req.operation == OP_ALLOC)) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                // all entries issued and the last read compared
                if (!issue && !r_rd_pend) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_block_count <= '0;
            r_marks       <= '0;
            r_addr        <= '0;
            r_limit       <= '0;
            r_rd_pend     <= 1'b0;
            r_have        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                r_block_count <= i_cfg_wdata;
            end

            if (ram_we) begin
                r_marks[ram_waddr] <= 1'b0;
            end

            if (req_xact) begin
                r_addr  <= '0;
                r_limit <= limit_sat;
                r_have  <= 1'b0;
            end

            r_rd_pend <= issue;
            if (issue) begin
                r_addr <= r_addr + CW'(1);
            end

            if (r_rd_pend && fits && better) begin
                r_have <= 1'b1;
            end

            // grant: mark the winner and publish the transaction
            if ((r_state == S_FINISH) && out_free) begin
                r_out_valid <= 1'b1;
                if (r_have) begin
                    r_marks[r_best] <= 1'b1;
                end
            end else if (rsp_xact) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (req_xact) begin
            r_req <= i_req.size;
        end

        if (issue) begin
            r_rd_idx  <= r_addr[AW-1:0];
            r_rd_mark <= r_marks[r_addr[AW-1:0]];
        end

        // strict greater keeps the lowest index on equal sizes
        if (r_rd_pend && fits && better) begin
            r_best      <= r_rd_idx;
            r_best_size <= ram_rdata;
        end

        if ((r_state == S_FINISH) && out_free) begin
            r_found <= r_have;
            r_gidx  <= r_have ? t_index'(r_best) : '0;
            r_frag  <= r_have ? (r_best_size - r_req) : '0;
        end
    end

endmodule

`default_nettype wire

// File: rtl/core/wfa_ram.sv
`default_nettype none

module wfa_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 32
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                       i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
